// ===== hdl/yad_pkg.sv =====
// ============================================================================
// yad_pkg: shared types and helpers for the yEnc article decoder
// Request and result payloads, the per-request op bundle passed from the
// parser to the result stage, character constants and the CRC-32 byte step.
// ============================================================================
`default_nettype none

package yad_pkg;

    // Most results one input byte can cause (broken trailer prefix + byte)
    localparam int MaxOps = 5;

    // Character codes
    localparam logic [7:0] CH_NUL = 8'h00;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_EQ  = 8'h3D;

    // yEnc offsets: plain bytes lose 42, escaped bytes lose 42 + 64
    localparam logic [7:0] ByteOff = 8'd42;
    localparam logic [7:0] EscOff  = 8'd106;

    localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
    localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       article_start;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic [31:0] crc_value;
        logic        last;
    } result_t;

    // One pending result, CRC not yet applied
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } op_t;

    // Everything one request causes, in order
    typedef struct packed {
        logic                  clear;
        logic [2:0]            cnt;
        op_t [MaxOps-1:0]      ops;
    } bundle_t;

    function automatic op_t mk_data(input logic [7:0] v);
        op_t o;
        o.kind = KIND_DATA;
        o.data = v;
        return o;
    endfunction

    // Characters of the "=yend " trailer prefix
    function automatic logic [7:0] yend_char(input logic [2:0] k);
        logic [7:0] c;
        unique case (k)
            3'd0:    c = 8'h3D;
            3'd1:    c = 8'h79;
            3'd2:    c = 8'h65;
            3'd3:    c = 8'h6E;
            3'd4:    c = 8'h64;
            3'd5:    c = 8'h20;
            default: c = 8'h3D;
        endcase
        return c;
    endfunction

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] v);
        logic [31:0] c;
        c = crc ^ {24'd0, v};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/yad_parse.sv =====
// ============================================================================
// yad_parse: line and escape parser
// Tracks line position, dot-stuffing, escapes and the trailer prefix, and
// turns each accepted request into a bundle of up to five pending results.
// ============================================================================
`default_nettype none

module yad_parse (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             accept,
    input  wire yad_pkg::item_t   item,
    output logic                  bund_valid,
    output yad_pkg::bundle_t      bund
);
    import yad_pkg::*;

    typedef enum logic [7:0] {
        PH_LINE  = 8'b0000_0001,
        PH_DATA  = 8'b0000_0010,
        PH_ESC   = 8'b0000_0100,
        PH_DOT   = 8'b0000_1000,
        PH_DOTCR = 8'b0001_0000,
        PH_YPFX  = 8'b0010_0000,
        PH_SKIP  = 8'b0100_0000,
        PH_HALT  = 8'b1000_0000
    } phase_t;

    phase_t           phase_reg, phase_next, ph_cur;
    logic [2:0]       pfx_reg, pfx_next, pfx_cur;
    logic [2:0]       k;
    logic [7:0]       b;
    logic [2:0]       n;
    op_t [MaxOps-1:0] ops;
    op_t              dot_op;

    // Plain byte handling
    logic             pl_emit;
    op_t              pl_op;
    phase_t           pl_phase;

    assign b      = item.in_byte;
    assign dot_op = mk_data(CH_DOT - ByteOff);

    always_comb
    begin
        pl_emit  = 1'b1;
        pl_op    = mk_data(b - ByteOff);
        pl_phase = PH_DATA;
        unique case (b)
            CH_NUL:
            begin
                pl_op.kind = KIND_ERR;
                pl_op.data = 8'd0;
                pl_phase   = PH_HALT;
            end
            CH_CR:
            begin
                pl_emit  = 1'b0;
                pl_phase = PH_DATA;
            end
            CH_LF:
            begin
                pl_emit  = 1'b0;
                pl_phase = PH_LINE;
            end
            CH_EQ:
            begin
                pl_emit  = 1'b0;
                pl_phase = PH_ESC;
            end
            default:
            begin
                pl_emit = 1'b1;
            end
        endcase
    end

    // Next state and result list
    always_comb
    begin
        ph_cur     = item.article_start ? PH_LINE : phase_reg;
        pfx_cur    = item.article_start ? 3'd0 : pfx_reg;
        phase_next = ph_cur;
        pfx_next   = pfx_cur;
        n          = 3'd0;
        ops        = '0;
        k          = (pfx_cur < 3'd1 || pfx_cur > 3'd5) ? 3'd1 : pfx_cur;
        unique case (ph_cur)
            PH_LINE, PH_DATA:
            begin
                if (ph_cur == PH_LINE && b == CH_DOT) begin
                    phase_next = PH_DOT;
                end else if (ph_cur == PH_LINE && b == CH_EQ) begin
                    phase_next = PH_YPFX;
                    pfx_next   = 3'd1;
                end else begin
                    ops[0]     = pl_op;
                    n          = {2'd0, pl_emit};
                    phase_next = pl_phase;
                end
            end
            PH_ESC:
            begin
                ops[0]     = mk_data(b - EscOff);
                n          = 3'd1;
                phase_next = PH_DATA;
            end
            PH_DOT, PH_DOTCR:
            begin
                if (b == CH_LF) begin
                    ops[0].kind = KIND_END;
                    ops[0].data = 8'd0;
                    n           = 3'd1;
                    phase_next  = PH_HALT;
                end else if (ph_cur == PH_DOT && b == CH_DOT) begin
                    // stuffed dot
                    ops[0]     = dot_op;
                    n          = 3'd1;
                    phase_next = PH_DATA;
                end else if (ph_cur == PH_DOT && b == CH_CR) begin
                    phase_next = PH_DOTCR;
                end else begin
                    // lone dot is data, then the byte itself
                    ops[0]     = dot_op;
                    ops[1]     = pl_op;
                    n          = 3'd1 + {2'd0, pl_emit};
                    phase_next = pl_phase;
                end
            end
            PH_YPFX:
            begin
                if (b == yend_char(k)) begin
                    if (k == 3'd5) begin
                        phase_next = PH_SKIP;
                        pfx_next   = 3'd0;
                    end else begin
                        pfx_next = k + 3'd1;
                    end
                end else begin
                    pfx_next = 3'd0;
                    if (k == 3'd1) begin
                        // byte after a lone '=' is escaped
                        ops[0]     = mk_data(b - EscOff);
                        n          = 3'd1;
                        phase_next = PH_DATA;
                    end else begin
                        // replay the matched prefix as data
                        ops[0] = mk_data(yend_char(3'd1) - EscOff);
                        for (int i = 1; i < 4; i++) begin
                            if (i + 2 <= int'(k)) begin
                                ops[i] = mk_data(yend_char(3'(i + 1)) - ByteOff);
                            end
                        end
                        ops[k - 3'd1] = pl_op;
                        n             = (k - 3'd1) + {2'd0, pl_emit};
                        phase_next    = pl_phase;
                    end
                end
            end
            PH_SKIP:
            begin
                if (b == CH_LF) begin
                    phase_next = PH_LINE;
                end
            end
            PH_HALT:
            begin
                phase_next = PH_HALT;
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase
    end

    assign bund.clear = item.article_start;
    assign bund.cnt   = n;
    assign bund.ops   = ops;
    assign bund_valid = accept && (n != 3'd0 || item.article_start);

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_LINE;
            pfx_reg   <= 3'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            pfx_reg   <= pfx_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/yad_emit.sv =====
// ============================================================================
// yad_emit: result stage
// Holds one op bundle, sends its results through the output register one
// per cycle unless stalled, and keeps the running CRC-32 over decoded bytes.
// ============================================================================
`default_nettype none

module yad_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              bund_load,
    input  wire yad_pkg::bundle_t  bund_in,
    output logic                   bund_stall,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output yad_pkg::result_t       result
);
    import yad_pkg::*;

    bundle_t     bund_reg;
    logic        bund_valid_reg, bund_valid_next;
    logic [2:0]  idx_reg, idx_next;
    logic [31:0] crc_reg, crc_next, crc_base;
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        out_free, fire, last_op, has_out;
    op_t         cur;

    assign out_free = !out_valid_reg || !result_stall;
    assign has_out  = bund_reg.cnt != 3'd0;
    assign cur      = bund_reg.ops[idx_reg];
    assign last_op  = !has_out || (idx_reg == bund_reg.cnt - 3'd1);
    assign fire     = bund_valid_reg && (!has_out || out_free);

    assign bund_stall = bund_valid_reg && !(fire && last_op);

    // CRC restarts ahead of the first op of an article-start bundle
    assign crc_base = (idx_reg == 3'd0 && bund_reg.clear) ? CrcInit : crc_reg;

    // Step through the bundle
    always_comb
    begin
        crc_next        = crc_reg;
        idx_next        = idx_reg;
        bund_valid_next = bund_valid_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        if (out_free) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            crc_next = crc_base;
            if (has_out) begin
                out_valid_next     = 1'b1;
                out_next.kind      = cur.kind;
                out_next.out_byte  = (cur.kind == KIND_DATA) ? cur.data : 8'd0;
                out_next.crc_value = (cur.kind == KIND_END) ? ~crc_base : 32'd0;
                out_next.last      = last_op;
                if (cur.kind == KIND_DATA) begin
                    crc_next = crc_byte(crc_base, cur.data);
                end
            end
            if (last_op) begin
                idx_next        = 3'd0;
                bund_valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 3'd1;
            end
        end
        if (bund_load) begin
            bund_valid_next = 1'b1;
        end
    end

    // Control and CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            bund_valid_reg <= 1'b0;
            idx_reg        <= 3'd0;
            crc_reg        <= CrcInit;
            out_valid_reg  <= 1'b0;
        end else begin
            bund_valid_reg <= bund_valid_next;
            idx_reg        <= idx_next;
            crc_reg        <= crc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (bund_load) begin
            bund_reg <= bund_in;
        end
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (bund_valid_reg && has_out) |-> (idx_reg < bund_reg.cnt))
        else $error("op index past bundle count");

    a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !bund_valid_reg |-> (idx_reg == 3'd0))
        else $error("op index not zero while bundle slot empty");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        bund_load |-> (!bund_valid_reg || (fire && last_op)))
        else $error("bundle loaded over a pending bundle");

    a_nondata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind != KIND_DATA) |-> (out_reg.out_byte == 8'd0))
        else $error("nonzero byte on end or error result");

endmodule

`default_nettype wire

// ===== hdl/yenc_article_decoder_unit.sv =====
// ============================================================================
// yenc_article_decoder_unit: yEnc article body decoder with CRC-32
// Top level: joins the line parser to the result stage.
// ============================================================================
// One body byte is taken per request, and a new byte can be taken every
// cycle while item_stall is low. A byte causes zero to five results (data
// byte, end of article or NUL error), sent in order on the single result
// port; a byte with several results holds the request side until its last
// result enters the output register. The parser works out all results of a
// byte combinationally; the result stage then sends them in order and folds
// each data byte into the CRC-32 on its way out. After end of article or a
// NUL error no results appear until a request with article_start set.
`default_nettype none

module yenc_article_decoder_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire yad_pkg::item_t   item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output yad_pkg::result_t      result
);
    import yad_pkg::*;

    logic    accept;
    logic    bund_valid;
    logic    bund_stall;
    bundle_t bund;

    assign item_stall = bund_stall;
    assign accept     = item_valid && !bund_stall;

    yad_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .item       (item),
        .bund_valid (bund_valid),
        .bund       (bund)
    );

    yad_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .bund_load    (bund_valid),
        .bund_in      (bund),
        .bund_stall   (bund_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== tb/tb_yenc_article_decoder_unit.sv =====
// ============================================================================
// tb_yenc_article_decoder_unit: self-checking bench for the yEnc decoder
// Drives article body bytes over the valid/stall request port and checks
// every result against an in-bench decoder model (dot-stuffing, escapes,
// trailer skip, CRC-32). A directed table comes first, then random articles
// under several idle/stall mixes, a long receiver hold-off and drain pauses.
// ============================================================================
module tb_yenc_article_decoder_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import yad_pkg::*;

    localparam int         ITEMS      = 470;
    localparam int         DRAIN_CYC  = 16;
    localparam int         HOLD_CYC   = 250;
    localparam int         MAX_REPORT = 10;
    localparam logic [7:0] PLAIN_SHIFT = 8'd42;
    localparam logic [7:0] ESC_SHIFT   = 8'd106;
    localparam logic [31:0] CRC32_POLY = 32'hEDB8_8320;
    localparam logic [47:0] TRAILER_TXT = "=yend ";

    // Decoder model states
    typedef enum logic [2:0] {
        ST_LINE, ST_DATA, ST_ESC, ST_DOT, ST_DOTCR, ST_YPFX, ST_SKIP, ST_HALT
    } parse_st_t;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_PRED, ROW_NONE, ROW_ONE
    } row_mode_t;

    typedef struct {
        item_t     it;
        row_mode_t mode;
        result_t   want;
    } row_t;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Model state
    parse_st_t   pst;
    logic [2:0]  pfx_cnt;
    logic [31:0] crc_acc;

    result_t step_res[$];
    result_t expect_q[$];
    row_t    dir_rows[$];

    int fail_cnt;
    int live_cnt;
    int send_pct;
    int stall_pct;
    int hold_cycles;
    bit art_start;

    yenc_article_decoder_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic logic [7:0] trailer_chr(input int i);
        return TRAILER_TXT[8*(5-i) +: 8];
    endfunction

    function automatic void add_res(input kind_t k, input logic [7:0] b,
                                    input logic [31:0] c);
        result_t r;
        r.kind      = k;
        r.out_byte  = b;
        r.crc_value = c;
        r.last      = 1'b0;
        step_res.push_back(r);
    endfunction

    // Decoded byte: fold into CRC, LSB first
    function automatic void add_data(input logic [7:0] v);
        logic [31:0] c;
        c = crc_acc ^ {24'h0, v};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC32_POLY) : (c >> 1);
        end
        crc_acc = c;
        add_res(KIND_DATA, v, 32'h0);
    endfunction

    function automatic void close_article();
        add_res(KIND_END, 8'h00, ~crc_acc);
        pst = ST_HALT;
    endfunction

    function automatic void plain_byte(input logic [7:0] b);
        if (b == CH_NUL)
        begin
            add_res(KIND_ERR, 8'h00, 32'h0);
            pst = ST_HALT;
        end
        else if (b == CH_CR)
            pst = ST_DATA;
        else if (b == CH_LF)
            pst = ST_LINE;
        else if (b == CH_EQ)
            pst = ST_ESC;
        else
        begin
            add_data(b - PLAIN_SHIFT);
            pst = ST_DATA;
        end
    endfunction

    // Returns 1 when the byte reaches a live (not halted) decoder
    function automatic bit predict_item(input item_t it);
        logic [7:0] b;
        int         k;
        bit         live;
        result_t    r;
        step_res.delete();
        b = it.in_byte;
        if (it.article_start)
        begin
            crc_acc = 32'hFFFF_FFFF;
            pst     = ST_LINE;
            pfx_cnt = 3'd0;
        end
        live = (pst != ST_HALT);
        case (pst)
            ST_LINE:
            begin
                if (b == CH_DOT)
                    pst = ST_DOT;
                else if (b == CH_EQ)
                begin
                    pst     = ST_YPFX;
                    pfx_cnt = 3'd1;
                end
                else
                    plain_byte(b);
            end
            ST_DATA: plain_byte(b);
            ST_ESC:
            begin
                add_data(b - ESC_SHIFT);
                pst = ST_DATA;
            end
            ST_DOT:
            begin
                if (b == CH_DOT)
                begin
                    add_data(CH_DOT - PLAIN_SHIFT);
                    pst = ST_DATA;
                end
                else if (b == CH_LF)
                    close_article();
                else if (b == CH_CR)
                    pst = ST_DOTCR;
                else
                begin
                    add_data(CH_DOT - PLAIN_SHIFT);
                    plain_byte(b);
                end
            end
            ST_DOTCR:
            begin
                if (b == CH_LF)
                    close_article();
                else
                begin
                    add_data(CH_DOT - PLAIN_SHIFT);
                    plain_byte(b);
                end
            end
            ST_YPFX:
            begin
                k = pfx_cnt;
                if (k < 1 || k > 5)
                    k = 1;
                if (b == trailer_chr(k))
                begin
                    k++;
                    if (k >= 6)
                    begin
                        pst     = ST_SKIP;
                        pfx_cnt = 3'd0;
                    end
                    else
                        pfx_cnt = 3'(k);
                end
                else
                begin
                    pfx_cnt = 3'd0;
                    if (k == 1)
                    begin
                        // lone '=' escapes whatever follows
                        add_data(b - ESC_SHIFT);
                        pst = ST_DATA;
                    end
                    else
                    begin
                        // broken prefix: replay matched bytes as data
                        add_data(trailer_chr(1) - ESC_SHIFT);
                        for (int i = 2; i < k; i++)
                        begin
                            add_data(trailer_chr(i) - PLAIN_SHIFT);
                        end
                        plain_byte(b);
                    end
                end
            end
            ST_SKIP:
            begin
                if (b == CH_LF)
                    pst = ST_LINE;
            end
            default: ;
        endcase
        if (step_res.size() > 0)
        begin
            r = step_res.pop_back();
            r.last = 1'b1;
            step_res.push_back(r);
        end
        return live;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    task automatic send_request(input item_t it, input row_mode_t mode,
                                input result_t want);
        int gap;
        bit live;
        gap = 0;
        while (send_pct > 0 && gap < 30 && $urandom_range(99) < send_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        // accepted at this edge
        live = predict_item(it);
        if (live)
            live_cnt++;
        case (mode)
            ROW_PRED: foreach (step_res[i]) expect_q.push_back(step_res[i]);
            ROW_ONE:  expect_q.push_back(want);
            default:  ;
        endcase
    endtask

    // Sender pause until all results are back, then let the pipe settle
    task automatic drain_results();
        item_valid <= 1'b0;
        while (expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic add_row(input logic [7:0] b, input logic s, input row_mode_t m,
                           input kind_t k, input logic [7:0] ob, input logic [31:0] c);
        row_t r;
        r.it.in_byte       = b;
        r.it.article_start = s;
        r.mode             = m;
        r.want.kind        = k;
        r.want.out_byte    = ob;
        r.want.crc_value   = c;
        r.want.last        = 1'b1;
        dir_rows.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Random article pieces
    // ------------------------------------------------------------------
    task automatic put(input logic [7:0] b);
        item_t   it;
        result_t none;
        it.in_byte       = b;
        it.article_start = art_start;
        art_start        = 1'b0;
        none             = '0;
        send_request(it, ROW_PRED, none);
    endtask

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            put(s[i]);
        end
    endtask

    task automatic line_end();
        if ($urandom_range(1))
            put(CH_CR);
        put(CH_LF);
    endtask

    // Encoded payload bytes, critical ones escaped, some others too
    task automatic data_body(input int len);
        logic [7:0] e;
        for (int i = 0; i < len; i++)
        begin
            e = 8'($urandom_range(255)) + PLAIN_SHIFT;
            if (e == CH_NUL || e == CH_LF || e == CH_CR || e == CH_EQ ||
                $urandom_range(15) == 0)
            begin
                put(CH_EQ);
                put(e + 8'd64);
            end
            else
                put(e);
        end
    endtask

    task automatic data_line(input bit dotted);
        if (dotted)
        begin
            put(CH_DOT);
            put(CH_DOT);
        end
        data_body($urandom_range(1, 10));
        line_end();
    endtask

    task automatic trailer_line();
        put_str("=yend size=");
        repeat ($urandom_range(1, 4)) put(8'h30 + 8'($urandom_range(9)));
        if ($urandom_range(3) == 0)
            put(CH_NUL);
        put_str(" part=1");
        line_end();
    endtask

    task automatic broken_prefix_line();
        int         n;
        logic [7:0] b;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
        begin
            put(trailer_chr(i));
        end
        b = 8'($urandom_range(255));
        if (b == trailer_chr(n))
            b = 8'h51;
        put(b);
        data_body($urandom_range(0, 4));
        line_end();
    endtask

    task automatic noise_line();
        repeat ($urandom_range(1, 6))
        begin
            case ($urandom_range(15))
                0:       put(CH_NUL);
                1, 2:    put(CH_LF);
                3, 4:    put(CH_CR);
                5, 6:    put(CH_DOT);
                7, 8:    put(CH_EQ);
                default: put(8'($urandom_range(255)));
            endcase
        end
        line_end();
    endtask

    task automatic random_article();
        int sel;
        art_start = 1'b1;
        repeat ($urandom_range(1, 4))
        begin
            sel = $urandom_range(99);
            if (sel < 45)
                data_line(1'b0);
            else if (sel < 55)
                data_line(1'b1);
            else if (sel < 68)
                trailer_line();
            else if (sel < 82)
                broken_prefix_line();
            else
                noise_line();
        end
        // terminating dot line, LF or CRLF
        if ($urandom_range(9) != 0)
        begin
            put(CH_DOT);
            if ($urandom_range(1))
                put(CH_CR);
            put(CH_LF);
        end
        // junk that a halted decoder drops
        if ($urandom_range(3) == 0)
            repeat ($urandom_range(1, 3)) put(8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int n;
        result_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                n           = hold_cycles;
                hold_cycles = 0;
                result_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            else
                result_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
        end
    end

    task automatic check_result(input result_t got);
        result_t want;
        if (expect_q.size() == 0)
        begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORT)
                $display("unexpected result: kind=%0d byte=%02h crc=%08h last=%0b",
                         got.kind, got.out_byte, got.crc_value, got.last);
        end
        else
        begin
            want = expect_q.pop_front();
            if (got.kind !== want.kind || got.out_byte !== want.out_byte ||
                got.crc_value !== want.crc_value || got.last !== want.last)
            begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORT)
                    $display({"mismatch: expected kind=%0d byte=%02h crc=%08h last=%0b,",
                              " got kind=%0d byte=%02h crc=%08h last=%0b"},
                             want.kind, want.out_byte, want.crc_value, want.last,
                             got.kind, got.out_byte, got.crc_value, got.last);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            check_result(result);
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        rst_n       = 1'b0;
        item_valid  = 1'b0;
        item        = '0;
        fail_cnt    = 0;
        live_cnt    = 0;
        send_pct    = 0;
        stall_pct   = 0;
        hold_cycles = 0;
        art_start   = 1'b0;
        pst         = ST_LINE;
        pfx_cnt     = 3'd0;
        crc_acc     = 32'hFFFF_FFFF;

        // byte, start, check, typed kind / byte / crc
        add_row(8'h6B,  1'b1, ROW_ONE,  KIND_DATA, 8'h41, 32'h0);  // first byte after reset
        add_row(8'hFF,  1'b0, ROW_ONE,  KIND_DATA, 8'hD5, 32'h0);
        add_row(CH_EQ,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_NUL, 1'b0, ROW_ONE,  KIND_DATA, 8'h96, 32'h0);  // escaped NUL is data
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);  // LF at line start
        add_row(CH_CR,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);  // CR at line start
        add_row(CH_DOT, 1'b0, ROW_ONE,  KIND_DATA, 8'h04, 32'h0);  // ...so dot is data
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_DOT, 1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_DOT, 1'b0, ROW_ONE,  KIND_DATA, 8'h04, 32'h0);  // dot-stuffed
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_DOT, 1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_CR,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h62,  1'b0, ROW_PRED, KIND_DATA, 8'h00, 32'h0);  // dot CR then data
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_EQ,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);  // broken "=yend"
        add_row(8'h79,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h65,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h6E,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h64,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h58,  1'b0, ROW_PRED, KIND_DATA, 8'h00, 32'h0);  // five results
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_DOT, 1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h61,  1'b0, ROW_PRED, KIND_DATA, 8'h00, 32'h0);  // lone dot
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_EQ,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_LF,  1'b0, ROW_ONE,  KIND_DATA, 8'hA0, 32'h0);  // lone '=' escapes LF
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_EQ,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);  // skipped trailer
        add_row(8'h79,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h65,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h6E,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h64,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(8'h20,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_NUL, 1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_LF,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_DOT, 1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_LF,  1'b0, ROW_PRED, KIND_DATA, 8'h00, 32'h0);  // end, LF form
        add_row(CH_DOT, 1'b1, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_CR,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);
        add_row(CH_LF,  1'b0, ROW_ONE,  KIND_END,  8'h00, 32'h0);  // empty article
        add_row(CH_NUL, 1'b1, ROW_ONE,  KIND_ERR,  8'h00, 32'h0);
        add_row(8'h62,  1'b0, ROW_NONE, KIND_DATA, 8'h00, 32'h0);  // halted

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (dir_rows[i])
        begin
            send_request(dir_rows[i].it, dir_rows[i].mode, dir_rows[i].want);
        end
        drain_results();
        live_cnt = 0;

        // random articles under four idle/stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_pct = 0;  stall_pct = 0;  end
                1:       begin send_pct = 57; stall_pct = 0;  end
                2:       begin send_pct = 0;  stall_pct = 57; end
                default: begin send_pct = 38; stall_pct = 38; end
            endcase
            // receiver backs off hard while requests keep coming
            if (ph == 0)
                hold_cycles = HOLD_CYC;
            while (live_cnt < (ph + 1) * ITEMS / 4)
                random_article();
            drain_results();
        end

        if (fail_cnt == 0 && expect_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/yad_pkg.sv
hdl/yad_parse.sv
hdl/yad_emit.sv
hdl/yenc_article_decoder_unit.sv
tb/tb_yenc_article_decoder_unit.sv
